// ===== rtl/cub_pkg.sv =====
`default_nettype none

package cub_pkg;

  // Field widths fixed by the request and result formats
  localparam int SLOT_W   = 6;
  localparam int STAMP_W  = 64;
  localparam int WEIGHT_W = 32;
  localparam int TOTAL_W  = 7;

  // Request operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  // Drain sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  // Write port of the slot data memory
  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   addr;
    logic [STAMP_W-1:0]  stamp;
    logic [WEIGHT_W-1:0] weight;
  } slot_wr_t;

  // Read port of the slot data memory
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } slot_rd_t;

endpackage

`default_nettype wire

// ===== rtl/cub_slot_mem.sv =====
`default_nettype none

module cub_slot_mem #(
  parameter int SLOTS = 64
) (
  input  logic                                    clk,
  input  cub_pkg::slot_wr_t                       wr,
  input  cub_pkg::slot_rd_t                       rd,
  output logic signed [cub_pkg::STAMP_W-1:0]      rd_stamp,
  output logic        [cub_pkg::WEIGHT_W-1:0]     rd_weight
);
  import cub_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [STAMP_W-1:0]  stamp_mem  [SLOTS];
  logic [WEIGHT_W-1:0] weight_mem [SLOTS];

  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;

  assign wr_idx = wr.addr[IDX_W-1:0];
  assign rd_idx = rd.addr[IDX_W-1:0];

  // Write the latest stamp and weight of a slot
  always_ff @(posedge clk) begin
    if (wr.en) begin
      stamp_mem[wr_idx]  <= wr.stamp;
      weight_mem[wr_idx] <= wr.weight;
    end
  end

  // Registered read; hold the data between reads
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_stamp  <= $signed(stamp_mem[rd_idx]);
      rd_weight <= weight_mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/coalescing_update_buffer_top.sv =====
`default_nettype none

// Channel   Handshake              Payload
// --------  ---------------------  ---------------------------------------------------
// request   req_valid / req_ready  op, slot, step_stamp, weight_bits
// result    res_valid / res_ready  out_slot, out_stamp, out_weight, total_dirty,
//                                  empty_res, last
//
// Updates are accepted back to back.
// For each dirty slot a drain reads the touch list, then the slot memory, and can be
// held by stalls on the result side; an empty drain gives a single empty result.
// Reset clears the dirty flags, the dirty count and the sequencer at once.
// No request is accepted while a drain is in progress.
module coalescing_update_buffer_top #(
  parameter int SLOTS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_ready,
  input  logic                                   op,
  input  logic        [cub_pkg::SLOT_W-1:0]      slot,
  input  logic signed [cub_pkg::STAMP_W-1:0]     step_stamp,
  input  logic        [cub_pkg::WEIGHT_W-1:0]    weight_bits,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output logic        [cub_pkg::SLOT_W-1:0]      out_slot,
  output logic signed [cub_pkg::STAMP_W-1:0]     out_stamp,
  output logic        [cub_pkg::WEIGHT_W-1:0]    out_weight,
  output logic        [cub_pkg::TOTAL_W-1:0]     total_dirty,
  output logic                                   empty_res,
  output logic                                   last
);
  import cub_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  state_t state;
  state_t state_next;

  logic [SLOTS-1:0] dirty;
  logic [CNT_W-1:0] dirty_count;
  logic [CNT_W-1:0] run_total;
  logic [CNT_W-1:0] run_idx;
  logic [CNT_W-1:0] run_idx_inc;
  logic             run_final;

  logic [IDX_W-1:0] touch_order [SLOTS];
  logic [IDX_W-1:0] touch_q;
  logic             touch_re;
  logic [IDX_W-1:0] touch_raddr;

  logic [IDX_W-1:0] slot_idx;
  logic             accept;
  logic             in_range;
  logic             upd;
  logic             upd_new;
  logic             drn;
  logic             res_free;
  logic             load_entry;
  logic             load_empty;

  slot_wr_t                mem_wr;
  slot_rd_t                mem_rd;
  logic signed [STAMP_W-1:0] rd_stamp;
  logic [WEIGHT_W-1:0]     rd_weight;

  // Decode the accepted request
  assign accept   = req_valid && req_ready;
  assign slot_idx = slot[IDX_W-1:0];
  assign in_range = ({1'b0, slot} < TOTAL_W'(SLOTS));
  assign upd      = accept && (op == OP_UPDATE) && in_range;
  assign upd_new  = upd && !dirty[slot_idx];
  assign drn      = accept && (op == OP_DRAIN);
  assign res_free = !res_valid || res_ready;

  assign run_idx_inc = run_idx + CNT_W'(1);
  assign run_final   = (run_idx == (run_total - CNT_W'(1)));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (drn) begin
          state_next = (dirty_count == '0) ? ST_EMPTY : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_free) begin
          state_next = run_final ? ST_IDLE : ST_FETCH;
        end
      end
      ST_EMPTY: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_ready   = 1'b0;
    touch_re    = 1'b0;
    touch_raddr = '0;
    load_entry  = 1'b0;
    load_empty  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        touch_re  = drn && (dirty_count != '0);
      end
      ST_FETCH: begin
      end
      ST_EMIT: begin
        load_entry  = res_free;
        touch_re    = res_free && !run_final;
        touch_raddr = run_idx_inc[IDX_W-1:0];
      end
      ST_EMPTY: begin
        load_empty = res_free;
      end
      default: begin
      end
    endcase
  end

  // Slot memory ports
  always_comb begin
    mem_wr.en     = upd;
    mem_wr.addr   = slot;
    mem_wr.stamp  = step_stamp;
    mem_wr.weight = weight_bits;
    mem_rd.en     = (state == ST_FETCH);
    mem_rd.addr   = SLOT_W'(touch_q);
  end

  cub_slot_mem #(
    .SLOTS(SLOTS)
  ) u_slot_mem (
    .clk       (clk),
    .wr        (mem_wr),
    .rd        (mem_rd),
    .rd_stamp  (rd_stamp),
    .rd_weight (rd_weight)
  );

  // Dirty flags, count, sequencer and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      dirty       <= '0;
      dirty_count <= '0;
      run_idx     <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (upd_new) begin
        dirty[slot_idx] <= 1'b1;
        dirty_count     <= dirty_count + CNT_W'(1);
      end
      if (drn) begin
        dirty       <= '0;
        dirty_count <= '0;
        run_idx     <= '0;
      end
      if (load_entry) begin
        run_idx <= run_idx_inc;
      end
      if (load_entry || load_empty) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Latch the run length at drain start
  always_ff @(posedge clk) begin
    if (drn) begin
      run_total <= dirty_count;
    end
  end

  // Touch list: append on first touch, read one entry per result
  always_ff @(posedge clk) begin
    if (upd_new) begin
      touch_order[dirty_count[IDX_W-1:0]] <= slot_idx;
    end
    if (touch_re) begin
      touch_q <= touch_order[touch_raddr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_entry) begin
      out_slot    <= SLOT_W'(touch_q);
      out_stamp   <= rd_stamp;
      out_weight  <= rd_weight;
      total_dirty <= TOTAL_W'(run_total);
      empty_res   <= 1'b0;
      last        <= run_final;
    end else if (load_empty) begin
      out_slot    <= '0;
      out_stamp   <= '0;
      out_weight  <= '0;
      total_dirty <= '0;
      empty_res   <= 1'b1;
      last        <= 1'b1;
    end
  end

  // Dirty count always matches the number of dirty flags
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(dirty) == int'(dirty_count))
    else $error("dirty count does not match dirty flags");

  // The count never exceeds the number of slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(dirty_count) <= SLOTS)
    else $error("dirty count above slot count");

  // A drain clears all dirty state by the next cycle
  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    drn |=> (dirty == '0) && (dirty_count == '0))
    else $error("drain left dirty state behind");

  // A nonempty result carries a nonzero run length
  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !empty_res) |-> (total_dirty != '0))
    else $error("nonempty result with zero run length");

  // The sequencer emits results only for entries inside the run
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (run_idx < run_total))
    else $error("drain index past run length");

endmodule

`default_nettype wire

// ===== tb/coalescing_update_buffer_top_test.sv =====
`timescale 1ns / 100ps

module coalescing_update_buffer_top_test;
  import cub_pkg::*;

  localparam int NUM_SLOTS    = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;

  localparam logic signed [STAMP_W-1:0] STAMP_MIN = {1'b1, {(STAMP_W-1){1'b0}}};
  localparam logic signed [STAMP_W-1:0] STAMP_MAX = {1'b0, {(STAMP_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0]       WEIGHT_ALL_ONES = '1;

  // One drained slot as it should appear on the result channel
  typedef struct {
    logic [SLOT_W-1:0]          slot;
    logic signed [STAMP_W-1:0]  stamp;
    logic [WEIGHT_W-1:0]        weight;
    logic [TOTAL_W-1:0]         total;
    logic                       empty;
    logic                       last;
  } drained_slot_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_ready;
  logic                       op = OP_UPDATE;
  logic [SLOT_W-1:0]          slot = '0;
  logic signed [STAMP_W-1:0]  step_stamp = '0;
  logic [WEIGHT_W-1:0]        weight_bits = '0;
  logic                       res_valid;
  logic                       res_ready = 1'b0;
  logic [SLOT_W-1:0]          out_slot;
  logic signed [STAMP_W-1:0]  out_stamp;
  logic [WEIGHT_W-1:0]        out_weight;
  logic [TOTAL_W-1:0]         total_dirty;
  logic                       empty_res;
  logic                       last;

  // Shadow copy of the buffer contents
  bit                         slot_is_dirty [NUM_SLOTS];
  logic [SLOT_W-1:0]          first_touch_list [NUM_SLOTS];
  logic signed [STAMP_W-1:0]  slot_stamp [NUM_SLOTS];
  logic [WEIGHT_W-1:0]        slot_weight [NUM_SLOTS];
  int                         dirty_total = 0;

  drained_slot_t              drain_results_due [$];

  int send_idle_pct = 35;
  int recv_idle_pct = 48;
  int hold_len = 0;
  int hold_go = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int cycle_count = 0;
  int mismatch_count = 0;
  int requests_sent = 0;
  int drains_sent = 0;
  int empty_drains = 0;
  int results_checked = 0;

  coalescing_update_buffer_top #(
    .SLOTS(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .op(op),
    .slot(slot),
    .step_stamp(step_stamp),
    .weight_bits(weight_bits),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .out_slot(out_slot),
    .out_stamp(out_stamp),
    .out_weight(out_weight),
    .total_dirty(total_dirty),
    .empty_res(empty_res),
    .last(last)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("coalescing_update_buffer_top test failed");
      $finish;
    end
  end

  // Drive result-side backpressure; a requested hold-off overrides random stalls
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Apply one accepted request to the shadow buffer; queue what a drain emits
  task automatic coalesce_or_drain(input logic op_i, input logic [SLOT_W-1:0] slot_i,
                                   input logic signed [STAMP_W-1:0] stamp_i,
                                   input logic [WEIGHT_W-1:0] weight_i);
    drained_slot_t entry;
    logic [SLOT_W-1:0] s;
    if (op_i == OP_UPDATE) begin
      if (!slot_is_dirty[slot_i]) begin
        slot_is_dirty[slot_i] = 1'b1;
        first_touch_list[dirty_total] = slot_i;
        dirty_total++;
      end
      slot_stamp[slot_i] = stamp_i;
      slot_weight[slot_i] = weight_i;
    end else if (dirty_total == 0) begin
      entry = '{default: '0};
      entry.empty = 1'b1;
      entry.last = 1'b1;
      drain_results_due.insert(drain_results_due.size(), entry);
      empty_drains++;
    end else begin
      for (int k = 0; k < dirty_total; k++) begin
        s = first_touch_list[k];
        entry.slot = s;
        entry.stamp = slot_stamp[s];
        entry.weight = slot_weight[s];
        entry.total = TOTAL_W'(dirty_total);
        entry.empty = 1'b0;
        entry.last = (k == dirty_total - 1);
        drain_results_due.insert(drain_results_due.size(), entry);
        slot_is_dirty[s] = 1'b0;
      end
      dirty_total = 0;
    end
  endtask

  // Offer one request, idling first at the current rate; valid stays up after accept
  task automatic send_request(input logic op_i, input logic [SLOT_W-1:0] slot_i,
                              input logic signed [STAMP_W-1:0] stamp_i,
                              input logic [WEIGHT_W-1:0] weight_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    op <= op_i;
    slot <= slot_i;
    step_stamp <= stamp_i;
    weight_bits <= weight_i;
    do @(posedge clk); while (!req_ready);
    coalesce_or_drain(op_i, slot_i, stamp_i, weight_i);
    requests_sent++;
    if (op_i == OP_DRAIN) drains_sent++;
  endtask

  task automatic send_update(input logic [SLOT_W-1:0] slot_i,
                             input logic signed [STAMP_W-1:0] stamp_i,
                             input logic [WEIGHT_W-1:0] weight_i);
    send_request(OP_UPDATE, slot_i, stamp_i, weight_i);
  endtask

  // Drain payload is ignored by the block, so fill it with noise
  task automatic send_drain();
    send_request(OP_DRAIN, SLOT_W'($urandom), {$urandom, $urandom}, $urandom);
  endtask

  // Stop offering, then wait for every expected result plus a short settle
  task automatic wait_results_drained();
    req_valid <= 1'b0;
    while (drain_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    drained_slot_t want;
    if (!rst && res_valid && res_ready) begin
      if (drain_results_due.size() == 0) begin
        $error("unexpected result: out_slot 0x%0h out_stamp 0x%0h empty_res %0b",
               out_slot, out_stamp, empty_res);
        mismatch_count++;
      end else begin
        want = drain_results_due.pop_front();
        compare_field("out_slot", 64'(want.slot), 64'(out_slot));
        compare_field("out_stamp", want.stamp, out_stamp);
        compare_field("out_weight", 64'(want.weight), 64'(out_weight));
        compare_field("total_dirty", 64'(want.total), 64'(total_dirty));
        compare_field("empty_res", 64'(want.empty), 64'(empty_res));
        compare_field("last", 64'(want.last), 64'(last));
        results_checked++;
      end
    end
  end

  function automatic logic signed [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(15))
      0: return STAMP_MIN;
      1: return STAMP_MAX;
      2: return '0;
      3: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(15))
      0: return '0;
      1: return WEIGHT_ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  // Empty drains, field extremes, coalescing and first-touch ordering
  task automatic test_directed_cases();
    send_drain();
    send_drain();
    send_update(0, STAMP_MAX, WEIGHT_ALL_ONES);
    send_update(63, STAMP_MIN, '0);
    send_update(0, '1, 32'h1234_5678);
    send_update(31, '0, 32'h8000_0000);
    send_drain();
    send_drain();
    send_update(5, 64'sd1, 32'h0000_0001);
    send_drain();
    send_update(42, 64'sh5555_5555_5555_5555, 32'hAAAA_AAAA);
    send_update(17, 64'shAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    send_update(42, -64'sd7, 32'hDEAD_BEEF);
    send_update(17, 64'sd99, 32'h0BAD_F00D);
    send_update(42, STAMP_MIN, WEIGHT_ALL_ONES);
    send_drain();
    send_update(63, STAMP_MAX, '0);
    send_update(0, STAMP_MIN, WEIGHT_ALL_ONES);
    send_drain();
    wait_results_drained();
  endtask

  // Mostly updates into a small hot set of slots, with drains now and then
  task automatic test_random_traffic(input int count);
    int pool_base;
    int pick;
    pool_base = $urandom_range(NUM_SLOTS - 8);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_drain();
        send_drain();
      end else if (pick < 12) begin
        send_drain();
        pool_base = $urandom_range(NUM_SLOTS - 8);
      end else if (pick < 60) begin
        send_update(SLOT_W'(pool_base + $urandom_range(7)), pick_stamp(), pick_weight());
      end else begin
        send_update(SLOT_W'($urandom_range(NUM_SLOTS - 1)), pick_stamp(), pick_weight());
      end
    end
    send_drain();
    wait_results_drained();
  endtask

  // Fill every slot while results are held off, so a full drain stalls the requests
  task automatic test_full_list_backpressure();
    int order [NUM_SLOTS];
    int j;
    int tmp;
    for (int i = 0; i < NUM_SLOTS; i++) order[i] = i;
    for (int i = NUM_SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    req_valid <= 1'b0;
    @(negedge clk);
    hold_len = HOLD_CYCLES;
    hold_go++;
    @(posedge clk);
    for (int i = 0; i < NUM_SLOTS; i++)
      send_update(SLOT_W'(order[i]), pick_stamp(), pick_weight());
    for (int i = 0; i < 10; i++)
      send_update(SLOT_W'($urandom_range(NUM_SLOTS - 1)), pick_stamp(), pick_weight());
    send_drain();
    for (int i = 0; i < 8; i++)
      send_update(SLOT_W'($urandom_range(NUM_SLOTS - 1)), pick_stamp(), pick_weight());
    send_drain();
    wait_results_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_traffic(60);

    send_idle_pct = 48;
    recv_idle_pct = 35;
    test_random_traffic(60);
    test_full_list_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(60);

    $display("Run covered %0d requests including %0d drains (%0d of them empty).",
             requests_sent, drains_sent, empty_drains);
    $display("%0d drained results compared, %0d field mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("coalescing_update_buffer_top test passed");
    end else begin
      $display("coalescing_update_buffer_top test failed");
    end
    $finish;
  end

endmodule
